// ----- src/ghp_pkg.sv -----
// generational handle pool: shared types and constants
// no dependencies
package ghp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WREAD,
        ST_WCHK,
        ST_WEND
    } t_state;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_ALLOC  = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_CHECK  = 3'd4;
    localparam logic [2:0] OP_LIST   = 3'd5;
    localparam logic [2:0] OP_DRAIN  = 3'd6;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    localparam logic [6:0]  LINK_NONE = 7'd127;
    localparam logic [31:0] GEN_MAX   = 32'hFFFF_FFFF;

endpackage

// ----- src/generational_handle_pool_top.sv -----
// generational handle pool: slot memories, free list and enumeration walker
// depends on ghp_pkg
//
// channel  direction  handshake                 payload
// request  in         i_in_valid / o_in_ready   operation, slot index, generation, data
// result   out        o_out_valid / i_out_ready status, index, generation, data, count, last
//
// single-slot requests read the slot memories into registers, then modify and write back
// list and drain walk every slot through a read state and a check state, then an end state
// a new request is taken only in idle; the result register decouples the output side
// reset is synchronous; generation and link stores use per-entry valid bits, no clearing pass
// a full result register stalls the walker or the execute step until it drains
module generational_handle_pool_top #(
    parameter int SLOTS     = 64,
    parameter int DATA_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_slot_index,
    input  logic [31:0] i_handle_generation,
    input  logic [63:0] i_data_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_result_index,
    output logic [31:0] o_result_generation,
    output logic [63:0] o_result_data,
    output logic [6:0]  o_live_count,
    output logic        o_last_result
);

    localparam int AW = $clog2(SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [6:0] SLOTS7 = 7'(SLOTS);

    logic [31:0]          r_gen_mem  [SLOTS];
    logic [6:0]           r_link_mem [SLOTS];
    logic [DATA_BITS-1:0] r_data_mem [SLOTS];

    logic [SLOTS-1:0] r_gv, r_lv, r_occ;
    logic [6:0]  r_head, r_total, n_head, n_total;
    ghp_pkg::t_state r_state, n_state;

    logic [2:0]  r_op;
    logic [31:0] r_sidx, r_hgen;
    logic [DATA_BITS-1:0] r_word;
    logic [AW-1:0] r_w;

    logic [31:0] r_gen_q;
    logic [6:0]  r_link_q;
    logic [DATA_BITS-1:0] r_data_q;
    logic        r_gv_q, r_lv_q;
    logic [AW-1:0] r_ra;

    logic        r_pv;
    logic [AW-1:0] r_pidx;
    logic [31:0] r_pgen;
    logic [DATA_BITS-1:0] r_pdata;

    logic        r_ov, r_olast;
    logic [1:0]  r_ostat;
    logic [5:0]  r_oidx;
    logic [31:0] r_ogen;
    logic [63:0] r_odata;
    logic [6:0]  r_olive;

    logic in_acc, out_free, rd_en;
    logic [AW-1:0] rd_addr, wa;
    logic we_gen, we_link, we_data, occ_set, occ_clr;
    logic [31:0] wd_gen;
    logic [6:0]  wd_link;
    logic [DATA_BITS-1:0] wd_data;
    logic [31:0] gen_e, gen_bump;
    logic [6:0]  link_e;
    logic is_alloc, is_drain, full, hok;
    logic load_out, n_last, pend_load, pend_clr, w_inc;
    logic [1:0]  n_ostat;
    logic [5:0]  n_oidx;
    logic [31:0] n_ogen;
    logic [63:0] n_odata;
    logic [6:0]  n_olive;

    assign in_acc   = i_in_valid && (r_state == ghp_pkg::ST_IDLE);
    assign out_free = !r_ov || i_out_ready;
    assign gen_e    = r_gv_q ? r_gen_q : 32'd0;
    assign gen_bump = (gen_e == ghp_pkg::GEN_MAX) ? gen_e : gen_e + 32'd1;
    assign link_e   = r_lv_q ? r_link_q :
                      ((r_ra == LAST_SLOT) ? ghp_pkg::LINK_NONE : 7'(r_ra) + 7'd1);
    assign is_alloc = (r_op == ghp_pkg::OP_INSERT) || (r_op == ghp_pkg::OP_ALLOC);
    assign is_drain = (r_op == ghp_pkg::OP_DRAIN);
    assign full     = r_head >= SLOTS7;
    assign hok      = (r_sidx < 32'(SLOTS)) && r_occ[r_sidx[AW-1:0]] && (gen_e == r_hgen);

    always_comb begin
        n_state   = r_state;
        rd_en     = 1'b0;
        rd_addr   = r_w;
        wa        = r_sidx[AW-1:0];
        we_gen    = 1'b0;
        we_link   = 1'b0;
        we_data   = 1'b0;
        occ_set   = 1'b0;
        occ_clr   = 1'b0;
        wd_gen    = gen_bump;
        wd_link   = r_head;
        wd_data   = (r_op == ghp_pkg::OP_INSERT) ? r_word : '0;
        n_head    = r_head;
        n_total   = r_total;
        load_out  = 1'b0;
        n_ostat   = ghp_pkg::ST_OK;
        n_oidx    = '0;
        n_ogen    = '0;
        n_odata   = '0;
        n_olive   = r_total;
        n_last    = 1'b1;
        pend_load = 1'b0;
        pend_clr  = 1'b0;
        w_inc     = 1'b0;
        unique case (r_state)
            ghp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    rd_en    = 1'b1;
                    pend_clr = 1'b1;
                    rd_addr  = ((i_operation == ghp_pkg::OP_INSERT) ||
                                (i_operation == ghp_pkg::OP_ALLOC)) ?
                               r_head[AW-1:0] : i_slot_index[AW-1:0];
                    if ((i_operation == ghp_pkg::OP_LIST) ||
                        (i_operation == ghp_pkg::OP_DRAIN)) begin
                        n_state = ghp_pkg::ST_WREAD;
                    end else if (i_operation == ghp_pkg::OP_UNUSED) begin
                        n_state = ghp_pkg::ST_IDLE;
                    end else begin
                        n_state = ghp_pkg::ST_EXEC;
                    end
                end
            end
            ghp_pkg::ST_EXEC: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ghp_pkg::ST_IDLE;
                    if (is_alloc) begin
                        wa = r_head[AW-1:0];
                        if (full) begin
                            n_ostat = ghp_pkg::ST_FULL;
                        end else begin
                            we_data = 1'b1;
                            occ_set = 1'b1;
                            n_head  = link_e;
                            n_total = r_total + 7'd1;
                            n_oidx  = 6'(r_head[AW-1:0]);
                            n_ogen  = gen_e;
                        end
                    end else if (!hok) begin
                        n_ostat = ghp_pkg::ST_INVALID;
                    end else begin
                        n_oidx = 6'(r_sidx[AW-1:0]);
                        n_ogen = gen_e;
                        if (r_op == ghp_pkg::OP_GET) begin
                            n_odata = 64'(r_data_q);
                        end else if (r_op == ghp_pkg::OP_REMOVE) begin
                            n_odata = 64'(r_data_q);
                            n_ogen  = gen_bump;
                            we_gen  = 1'b1;
                            we_link = 1'b1;
                            occ_clr = 1'b1;
                            n_head  = 7'(r_sidx[AW-1:0]);
                            n_total = r_total - 7'd1;
                        end
                    end
                    n_olive = n_total;
                end
            end
            ghp_pkg::ST_WREAD: begin
                rd_en   = 1'b1;
                n_state = ghp_pkg::ST_WCHK;
            end
            ghp_pkg::ST_WCHK: begin
                wa      = r_w;
                n_olive = is_drain ? 7'd0 : r_total;
                n_oidx  = 6'(r_pidx);
                n_ogen  = r_pgen;
                n_odata = 64'(r_pdata);
                n_last  = 1'b0;
                if (!r_occ[r_w] || !r_pv || out_free) begin
                    if (r_occ[r_w]) begin
                        pend_load = 1'b1;
                        load_out  = r_pv;
                        if (is_drain) begin
                            we_gen  = 1'b1;
                            we_link = 1'b1;
                            occ_clr = 1'b1;
                            n_head  = 7'(r_w);
                            n_total = r_total - 7'd1;
                        end
                    end
                    if (r_w == LAST_SLOT) begin
                        n_state = ghp_pkg::ST_WEND;
                    end else begin
                        w_inc   = 1'b1;
                        n_state = ghp_pkg::ST_WREAD;
                    end
                end
            end
            ghp_pkg::ST_WEND: begin
                n_olive = is_drain ? 7'd0 : r_total;
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ghp_pkg::ST_IDLE;
                    if (r_pv) begin
                        n_oidx  = 6'(r_pidx);
                        n_ogen  = r_pgen;
                        n_odata = 64'(r_pdata);
                    end else begin
                        n_ostat = ghp_pkg::ST_NONE;
                    end
                end
            end
            default: n_state = ghp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ghp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // slot memories, registered read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_gen_q  <= r_gen_mem[rd_addr];
            r_link_q <= r_link_mem[rd_addr];
            r_data_q <= r_data_mem[rd_addr];
        end
        if (we_gen) begin
            r_gen_mem[wa] <= wd_gen;
        end
        if (we_link) begin
            r_link_mem[wa] <= wd_link;
        end
        if (we_data) begin
            r_data_mem[wa] <= wd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv    <= '0;
            r_lv    <= '0;
            r_occ   <= '0;
            r_head  <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
            r_w     <= '0;
        end else begin
            if (we_gen)  r_gv[wa] <= 1'b1;
            if (we_link) r_lv[wa] <= 1'b1;
            if (occ_set) r_occ[wa] <= 1'b1;
            if (occ_clr) r_occ[wa] <= 1'b0;
            r_head  <= n_head;
            r_total <= n_total;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (pend_clr) begin
                r_pv <= 1'b0;
                r_w  <= '0;
            end else begin
                if (pend_load) r_pv <= 1'b1;
                if (w_inc) r_w <= r_w + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_gv_q <= r_gv[rd_addr];
            r_lv_q <= r_lv[rd_addr];
            r_ra   <= rd_addr;
        end
        if (in_acc) begin
            r_op   <= i_operation;
            r_sidx <= i_slot_index;
            r_hgen <= i_handle_generation;
            r_word <= i_data_word[DATA_BITS-1:0];
        end
        if (pend_load) begin
            r_pidx  <= r_w;
            r_pgen  <= is_drain ? gen_bump : gen_e;
            r_pdata <= is_drain ? r_data_q : '0;
        end
        if (load_out) begin
            r_ostat <= n_ostat;
            r_oidx  <= n_oidx;
            r_ogen  <= n_ogen;
            r_odata <= n_odata;
            r_olive <= n_olive;
            r_olast <= n_last;
        end
    end

    assign o_in_ready          = (r_state == ghp_pkg::ST_IDLE);
    assign o_out_valid         = r_ov;
    assign o_status            = r_ostat;
    assign o_result_index      = r_oidx;
    assign o_result_generation = r_ogen;
    assign o_result_data       = r_odata;
    assign o_live_count        = r_olive;
    assign o_last_result       = r_olast;

`ifndef SYNTH
    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        7'($countones(r_occ)) == r_total)
        else $error("occupied count mismatch");
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ghp_pkg::ST_OK)) |-> o_last_result)
        else $error("error result not marked last");
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation != ghp_pkg::OP_UNUSED)) |=> (r_state != ghp_pkg::ST_IDLE))
        else $error("request accepted but not executed");
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head < SLOTS7) || (r_head == ghp_pkg::LINK_NONE))
        else $error("free head out of range");
`endif

endmodule

// ----- test/ghp_checker.sv -----
// generational handle pool checker: watches both channels, predicts each result
// depends on ghp_pkg and the port list of generational_handle_pool_top
`timescale 1ns / 1ps
module ghp_checker #(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_slot_index,
    input  logic [31:0] i_handle_generation,
    input  logic [63:0] i_data_word,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [5:0]  i_result_index,
    input  logic [31:0] i_result_generation,
    input  logic [63:0] i_result_data,
    input  logic [6:0]  i_live_count,
    input  logic        i_last_result,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  index;
        logic [31:0] generation;
        logic [63:0] data;
        logic [6:0]  live;
        logic        last;
    } t_pool_result;

    t_pool_result pool_results_due[$];
    logic [31:0]  gen_mem [SLOTS];
    logic [6:0]   link_mem [SLOTS];
    logic         busy_mem [SLOTS];
    logic [63:0]  data_mem [SLOTS];
    logic [6:0]   head_slot;
    logic [6:0]   live_total;

    assign o_pending = pool_results_due.size();

    task automatic release_slot(input int s);
        if (gen_mem[s] != ghp_pkg::GEN_MAX) gen_mem[s] = gen_mem[s] + 32'd1;
        busy_mem[s]  = 1'b0;
        link_mem[s]  = head_slot;
        head_slot    = 7'(s);
        if (live_total != 0) live_total = live_total - 7'd1;
    endtask

    task automatic predict_pool(input logic [2:0] op, input logic [31:0] idx,
                                input logic [31:0] gen, input logic [63:0] word);
        t_pool_result r;
        int           walk[$];
        logic [63:0]  vals[$];
        logic         good;
        r    = '0;
        good = (idx < SLOTS) && busy_mem[idx[5:0]] && (gen_mem[idx[5:0]] == gen);
        r.last = 1'b1;
        case (op)
            ghp_pkg::OP_INSERT, ghp_pkg::OP_ALLOC: begin
                if (head_slot >= SLOTS) begin
                    r.status = ghp_pkg::ST_FULL;
                end else begin
                    r.index = head_slot[5:0];
                    head_slot = link_mem[r.index];
                    busy_mem[r.index] = 1'b1;
                    data_mem[r.index] = (op == ghp_pkg::OP_INSERT) ? word : '0;
                    live_total = live_total + 7'd1;
                    r.generation = gen_mem[r.index];
                    r.status = ghp_pkg::ST_OK;
                end
                r.live = live_total;
                pool_results_due.push_back(r);
            end
            ghp_pkg::OP_GET, ghp_pkg::OP_CHECK, ghp_pkg::OP_REMOVE: begin
                if (!good) begin
                    r.status = ghp_pkg::ST_INVALID;
                end else begin
                    r.index = idx[5:0];
                    if (op != ghp_pkg::OP_CHECK) r.data = data_mem[r.index];
                    if (op == ghp_pkg::OP_REMOVE) release_slot(r.index);
                    r.generation = gen_mem[r.index];
                end
                r.live = live_total;
                pool_results_due.push_back(r);
            end
            ghp_pkg::OP_LIST, ghp_pkg::OP_DRAIN: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (busy_mem[s]) begin
                        walk.push_back(s);
                        vals.push_back(op == ghp_pkg::OP_DRAIN ? data_mem[s] : 64'd0);
                        if (op == ghp_pkg::OP_DRAIN) release_slot(s);
                    end
                end
                if (walk.size() == 0) begin
                    r.status = ghp_pkg::ST_NONE;
                    r.live = live_total;
                    pool_results_due.push_back(r);
                end
                for (int k = 0; k < walk.size(); k++) begin
                    r.status = ghp_pkg::ST_OK;
                    r.index = 6'(walk[k]);
                    r.generation = gen_mem[walk[k]];
                    r.data = vals[k];
                    r.live = live_total;
                    r.last = (k == walk.size() - 1);
                    pool_results_due.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_pool_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                gen_mem[s]  = '0;
                link_mem[s] = (s + 1 < SLOTS) ? 7'(s + 1) : ghp_pkg::LINK_NONE;
                busy_mem[s] = 1'b0;
                data_mem[s] = '0;
            end
            head_slot  = '0;
            live_total = '0;
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (pool_results_due.size() == 0) begin
                    $display("%0t unexpected result: actual status %0d index %0d", $realtime,
                             i_status, i_result_index);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pool_results_due.pop_front();
                    if (want != {i_status, i_result_index, i_result_generation, i_result_data,
                                 i_live_count, i_last_result}) begin
                        o_errors <= o_errors + 1;
                        if (want.status != i_status)
                            $display("%0t status: expected %0d actual %0d", $realtime,
                                     want.status, i_status);
                        if (want.index != i_result_index)
                            $display("%0t index: expected %0d actual %0d", $realtime,
                                     want.index, i_result_index);
                        if (want.generation != i_result_generation)
                            $display("%0t generation: expected %h actual %h", $realtime,
                                     want.generation, i_result_generation);
                        if (want.data != i_result_data)
                            $display("%0t data: expected %h actual %h", $realtime,
                                     want.data, i_result_data);
                        if (want.live != i_live_count)
                            $display("%0t live count: expected %0d actual %0d", $realtime,
                                     want.live, i_live_count);
                        if (want.last != i_last_result)
                            $display("%0t last: expected %0d actual %0d", $realtime,
                                     want.last, i_last_result);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_pool(i_operation, i_slot_index, i_handle_generation, i_data_word);
        end
    end

endmodule

// ----- test/generational_handle_pool_top_test.sv -----
// generational handle pool testbench top: clock, reset, request stimulus, verdict
// depends on ghp_pkg, generational_handle_pool_top and ghp_checker
`timescale 1ns / 1ps
module generational_handle_pool_top_test;

    localparam int SLOTS = 64;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  operation = '0;
    logic [31:0] slot_index = '0;
    logic [31:0] handle_gen = '0;
    logic [63:0] data_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [5:0]  result_index;
    logic [31:0] result_gen;
    logic [63:0] result_data;
    logic [6:0]  live_count;
    logic        last_result;
    int          errors;
    int          pending;
    int          results;
    int          requests = 0;
    int          quiet_cycles = 0;
    bit          steady = 1'b0;
    logic [31:0] known_gen [SLOTS];

    always #4 clk = ~clk;

    generational_handle_pool_top #(.SLOTS(SLOTS), .DATA_BITS(64)) uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_operation(operation), .i_slot_index(slot_index),
        .i_handle_generation(handle_gen), .i_data_word(data_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_status(status),
        .o_result_index(result_index), .o_result_generation(result_gen),
        .o_result_data(result_data), .o_live_count(live_count),
        .o_last_result(last_result)
    );

    ghp_checker #(.SLOTS(SLOTS)) pool_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_operation(operation), .i_slot_index(slot_index),
        .i_handle_generation(handle_gen), .i_data_word(data_word),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_status(status),
        .i_result_index(result_index), .i_result_generation(result_gen),
        .i_result_data(result_data), .i_live_count(live_count),
        .i_last_result(last_result), .o_errors(errors), .o_pending(pending),
        .o_results(results)
    );

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            for (int s = 0; s < SLOTS; s++) known_gen[s] <= '0;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= 33);
            if (out_valid && out_ready && status == ghp_pkg::ST_OK)
                known_gen[result_index] <= result_gen;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog expired, %0d results still due", $realtime, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [31:0] idx,
                                input logic [31:0] gen, input logic [63:0] word);
        while (!steady && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        slot_index <= idx;
        handle_gen <= gen;
        data_word  <= word;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests++;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_handle_op(input logic [2:0] op);
        logic [31:0] idx;
        logic [31:0] gen;
        idx = $urandom_range(SLOTS - 1);
        gen = known_gen[idx[5:0]];
        case ($urandom_range(9))
            0: idx = $urandom();
            1: gen = $urandom();
            2: gen = gen + 32'd1;
            default: ;
        endcase
        send_request(op, idx, gen, rand_word());
    endtask

    initial begin
        int pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ghp_pkg::OP_LIST, '0, '0, '0);
        send_request(ghp_pkg::OP_DRAIN, '0, '0, '0);
        send_request(ghp_pkg::OP_GET, 32'd0, 32'd0, '0);
        send_request(ghp_pkg::OP_INSERT, '1, '1, '1);
        send_request(ghp_pkg::OP_INSERT, '0, '0, '0);
        send_request(ghp_pkg::OP_ALLOC, '0, '0, '1);
        send_request(ghp_pkg::OP_INSERT, '0, '0, 64'hA5A5_5A5A_F00D_1234);
        send_request(ghp_pkg::OP_GET, 32'd0, 32'd0, '0);
        send_request(ghp_pkg::OP_CHECK, 32'd1, 32'd0, '0);
        send_request(ghp_pkg::OP_GET, 32'd64, 32'd0, '0);
        send_request(ghp_pkg::OP_GET, '1, 32'd0, '0);
        send_request(ghp_pkg::OP_CHECK, 32'd2, '1, '0);
        send_request(ghp_pkg::OP_REMOVE, 32'd1, 32'd0, '0);
        send_request(ghp_pkg::OP_REMOVE, 32'd1, 32'd0, '0);
        send_request(ghp_pkg::OP_GET, 32'd1, 32'd1, '0);
        send_request(ghp_pkg::OP_UNUSED, '1, '1, '1);
        send_request(ghp_pkg::OP_ALLOC, '0, '0, '0);
        send_request(ghp_pkg::OP_LIST, '0, '0, '0);
        send_request(ghp_pkg::OP_DRAIN, '0, '0, '0);
        send_request(ghp_pkg::OP_LIST, '0, '0, '0);

        for (int n = 0; n < SLOTS + 2; n++)
            send_request(n[0] ? ghp_pkg::OP_ALLOC : ghp_pkg::OP_INSERT, $urandom(), $urandom(),
                         rand_word());
        send_request(ghp_pkg::OP_LIST, '0, '0, '0);

        for (int n = 0; n < 133; n++) begin
            steady = (n >= 60 && n < 100);
            pick = $urandom_range(99);
            if (pick < 30)
                send_request(ghp_pkg::OP_INSERT, $urandom(), $urandom(), rand_word());
            else if (pick < 38)
                send_request(ghp_pkg::OP_ALLOC, $urandom(), $urandom(), rand_word());
            else if (pick < 55) send_handle_op(ghp_pkg::OP_GET);
            else if (pick < 65) send_handle_op(ghp_pkg::OP_CHECK);
            else if (pick < 87) send_handle_op(ghp_pkg::OP_REMOVE);
            else if (pick < 92)
                send_request(ghp_pkg::OP_LIST, $urandom(), $urandom(), rand_word());
            else if (pick < 95)
                send_request(ghp_pkg::OP_DRAIN, $urandom(), $urandom(), rand_word());
            else
                send_request(3'($urandom()), $urandom(), $urandom(), rand_word());
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("ran %0d requests through the pool and checked %0d results", requests, results);
        $display("covered insert, alloc, get, check, remove, list, drain, full and bad handles");
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
